/* rtl/sidechain_compressor_core_assert.svh */
// Assertion macros shared by the compressor modules.
// Both expect a clock named i_clk in scope; SCC_ASSERT_RST also expects an active-low reset named i_rst_n.
`ifndef SIDECHAIN_COMPRESSOR_CORE_ASSERT_SVH
`define SIDECHAIN_COMPRESSOR_CORE_ASSERT_SVH

// Checked only while out of reset.
`define SCC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked at every rising clock edge, reset included.
`define SCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* rtl/scc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

    // Default sizes.
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int LOG_TABLE_DEPTH_DEF = 256;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RATIO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_EN   = 3'd5;

    // Register widths.
    localparam int THR_W    = 23;
    localparam int IR_W     = 17;
    localparam int COEF_W   = 24;
    localparam int MAKEUP_W = 20;
    localparam int GAIN_W   = 17;

    // Register reset values.
    localparam logic [THR_W-1:0]    THR_RST     = 23'd529292;
    localparam logic [IR_W-1:0]     IR_RST      = 17'd16384;
    localparam logic [COEF_W-1:0]   ATTACK_RST  = 24'd16707454;
    localparam logic [COEF_W-1:0]   RELEASE_RST = 24'd16774886;
    localparam logic [MAKEUP_W-1:0] MAKEUP_RST  = 20'd65536;
    localparam logic                SIDE_EN_RST = 1'b1;

    // Unity in Q1.16.
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'd65536;

    // Datapath commands, one strobe per sequencing step.
    typedef struct packed {
        logic load;
        logic env_mul;
        logic env_upd;
        logic log_step;
        logic exp_step;
        logic gain;
        logic scale;
        logic makeup;
        logic finish;
    } t_dp_cmd;

    // 2^(2^-k) in Q2.30 for k = 1 to 16.
    localparam logic [31:0] EXP_ROOT [16] = '{
        32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
        32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033,
        32'd1075196443, 32'd1074468887, 32'd1074105294, 32'd1073923544,
        32'd1073832680, 32'd1073787251, 32'd1073764537, 32'd1073753181
    };

    // Fractional log2 of 1 + i/depth in Q0.16, found by repeated squaring.
    function automatic logic [15:0] log_entry(input int unsigned i, input int unsigned lg);
        logic [63:0] y;
        logic [15:0] res;
        int          k;
        y   = (64'd1 << 30) + (64'(i) << (30 - lg));
        res = '0;
        for (k = 1; k <= 16; k++) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
                y = y >> 1;
                res[16-k] = 1'b1;
            end
        end
        return res;
    endfunction

    // 2^(i/depth) in Q1.16, built as a product of root constants.
    function automatic logic [16:0] exp_entry(input int unsigned i, input int unsigned lg);
        logic [63:0] f;
        logic [63:0] y;
        int          k;
        f = 64'(i) << (16 - lg);
        y = 64'd1 << 30;
        for (k = 1; k <= 16; k++) begin
            if (f[16-k]) begin
                y = (y * 64'(EXP_ROOT[k-1])) >> 30;
            end
        end
        return y[30:14];
    endfunction

endpackage

`default_nettype wire

/* rtl/scc_log2.sv */
`timescale 1ns / 1ps
`default_nettype none

// Log2 of an unsigned magnitude in Q.16: leading-one position plus a table
// lookup on the bits just below it.
module scc_log2 #(
    parameter int SAMPLE_BITS = scc_pkg::SAMPLE_BITS_DEF,
    parameter int LG_DEPTH    = 8
) (
    input  wire logic [SAMPLE_BITS-1:0]                i_x,
    output logic      [$clog2(SAMPLE_BITS)+16-1:0]     o_log
);

    localparam int P_BITS = $clog2(SAMPLE_BITS);
    localparam int DEPTH  = 1 << LG_DEPTH;
    localparam int SH_W   = SAMPLE_BITS + LG_DEPTH;

    logic [15:0]             w_tab [DEPTH];
    logic [P_BITS-1:0]       w_p;
    logic [SAMPLE_BITS-1:0]  w_frac;
    logic [SH_W-1:0]         w_sh;

    // Fraction table, fixed at elaboration.
    for (genvar g = 0; g < DEPTH; g++) begin : g_tab
        assign w_tab[g] = scc_pkg::log_entry(g, LG_DEPTH);
    end

    // Position of the highest set bit.
    always_comb begin
        w_p = '0;
        for (int b = 0; b < SAMPLE_BITS; b++) begin
            if (i_x[b]) begin
                w_p = P_BITS'(b);
            end
        end
    end

    // Bits below the leading one, aligned to the table index.
    assign w_frac = i_x ^ (SAMPLE_BITS'(1) << w_p);
    assign w_sh   = (SH_W'(w_frac) << LG_DEPTH) >> w_p;
    assign o_log  = {w_p, w_tab[w_sh[LG_DEPTH-1:0]]};

endmodule

`default_nettype wire

/* rtl/scc_controller.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "sidechain_compressor_core_assert.svh"

// Sequencer: walks one frame through the datapath steps and owns both handshakes.
module scc_controller (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output scc_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_ENV_MUL = 9'b000000010,
        ST_ENV_UPD = 9'b000000100,
        ST_LOG     = 9'b000001000,
        ST_EXP     = 9'b000010000,
        ST_GAIN    = 9'b000100000,
        ST_SCALE   = 9'b001000000,
        ST_MAKEUP  = 9'b010000000,
        ST_DONE    = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    // The output register may be loaded when empty or emptied in this cycle.
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Next state and command strobes.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_ENV_MUL;
                end
            end
            ST_ENV_MUL: begin
                o_cmd.env_mul = 1'b1;
                n_state       = ST_ENV_UPD;
            end
            ST_ENV_UPD: begin
                o_cmd.env_upd = 1'b1;
                n_state       = ST_LOG;
            end
            ST_LOG: begin
                o_cmd.log_step = 1'b1;
                n_state        = ST_EXP;
            end
            ST_EXP: begin
                o_cmd.exp_step = 1'b1;
                n_state        = ST_GAIN;
            end
            ST_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_MAKEUP;
            end
            ST_MAKEUP: begin
                o_cmd.makeup = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid: set when a result is loaded, cleared when the transaction completes.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `SCC_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (!r_out_valid && r_state == ST_IDLE), "reset did not clear the sequencer")
    `SCC_ASSERT_RST(a_no_overwrite, o_cmd.finish |-> !(r_out_valid && i_out_stall), "result loaded over a waiting result")
    `SCC_ASSERT_RST(a_accept_starts, w_accept |=> r_state == ST_ENV_MUL, "accepted frame did not start processing")

endmodule

`default_nettype wire

/* rtl/scc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "sidechain_compressor_core_assert.svh"

// Datapath: configuration registers, key detection, envelope, gain computer
// and output scaling, each step registered under command of the sequencer.
module scc_datapath #(
    parameter int SAMPLE_BITS = scc_pkg::SAMPLE_BITS_DEF,
    parameter int LG_DEPTH    = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire scc_pkg::t_dp_cmd                  i_cmd,
    input  wire logic                              i_cfg_valid,
    input  wire logic [scc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [scc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_main_left,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_main_right,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_side_left,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_side_right,
    output logic signed      [SAMPLE_BITS-1:0]     o_out_left,
    output logic signed      [SAMPLE_BITS-1:0]     o_out_right,
    output logic [scc_pkg::GAIN_W-1:0]             o_gain_applied
);

    localparam int SB       = SAMPLE_BITS;
    localparam int DEPTH    = 1 << LG_DEPTH;
    localparam int LOG_W    = $clog2(SB) + 16;
    localparam int E_W      = LOG_W + 1;
    localparam int N_W      = E_W - 15;
    localparam int GW       = scc_pkg::GAIN_W;
    localparam int MW       = scc_pkg::MAKEUP_W;
    localparam int CW       = scc_pkg::COEF_W;
    localparam int P_W      = SB + GW;
    localparam int PH_W     = P_W - 32;
    localparam int HI_W     = PH_W + MW;
    localparam int LO_W     = 32 + MW;
    localparam int SUM_W    = SB + 6;
    localparam int DPROD_W  = SB + CW;
    // Smallest key that is not silent: key * 1e6 >= full scale.
    localparam logic [63:0] FLOOR64 = ((64'd1 << (SB - 1)) + 64'd999999) / 64'd1000000;
    localparam logic [SB-1:0] KEY_FLOOR = FLOOR64[SB-1:0];

    // Configuration registers.
    logic [scc_pkg::THR_W-1:0] r_thr;
    logic [scc_pkg::IR_W-1:0]  r_ir;
    logic [CW-1:0]             r_att;
    logic [CW-1:0]             r_rel;
    logic [MW-1:0]             r_mk;
    logic                      r_side;

    // Frame registers.
    logic signed [SB-1:0] r_ml, r_mr;
    logic [SB-1:0]        r_key;
    logic [SB-1:0]        r_env;
    logic                 r_rise;
    logic [DPROD_W-1:0]   r_dprod;
    logic                 r_above;
    logic [LOG_W-1:0]     r_l;
    logic [E_W-1:0]       r_e;
    logic [GW-1:0]        r_gain;
    logic [P_W-1:0]       r_p_l, r_p_r;
    logic [HI_W-1:0]      r_hi_l, r_hi_r;
    logic [LO_W-1:0]      r_lo_l, r_lo_r;
    logic signed [SB-1:0] r_out_l, r_out_r;
    logic [GW-1:0]        r_out_g;

    logic [SB-1:0]        w_mag_sl, w_mag_sr, w_mag_ml, w_mag_mr;
    logic [SB-1:0]        w_side_key, w_main_key, w_key;
    logic                 w_fallback;
    logic [SB-1:0]        w_diff;
    logic [SB-2:0]        w_thr_raw;
    logic [SB-1:0]        w_thr;
    logic [LOG_W-1:0]     w_le, w_lt;
    logic [GW-1:0]        w_ir, w_cr;
    logic [LOG_W+GW-1:0]  w_eprod;
    logic [E_W:0]         w_esum;
    logic [N_W-1:0]       w_n;
    logic [15:0]          w_rem;
    logic [GW-1:0]        w_etab [DEPTH];
    logic [GW-1:0]        w_exp;
    logic [GW-1:0]        w_gain;

    function automatic logic [SB-1:0] mag_of(input logic signed [SB-1:0] s);
        return s[SB-1] ? SB'(-s) : SB'(s);
    endfunction

    function automatic logic [SB-1:0] max_of(input logic [SB-1:0] a, input logic [SB-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Rounded sum of the makeup partial products, then saturation with the sign restored.
    function automatic logic signed [SB-1:0] finish_of(input logic [HI_W-1:0] hi,
                                                        input logic [LO_W-1:0] lo,
                                                        input logic neg);
        logic [LO_W:0]    lor;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] top;
        lor = (LO_W + 1)'(lo) + ((LO_W + 1)'(1) << 31);
        sum = SUM_W'(hi) + SUM_W'(lor[LO_W:32]);
        top = SUM_W'(1) << (SB - 1);
        if (neg) begin
            if (sum > top) begin
                sum = top;
            end
            return SB'(-sum);
        end
        if (sum > top - SUM_W'(1)) begin
            sum = top - SUM_W'(1);
        end
        return SB'(sum);
    endfunction

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= scc_pkg::THR_RST;
            r_ir   <= scc_pkg::IR_RST;
            r_att  <= scc_pkg::ATTACK_RST;
            r_rel  <= scc_pkg::RELEASE_RST;
            r_mk   <= scc_pkg::MAKEUP_RST;
            r_side <= scc_pkg::SIDE_EN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                scc_pkg::CFG_THRESHOLD: r_thr  <= i_cfg_data[scc_pkg::THR_W-1:0];
                scc_pkg::CFG_INV_RATIO: r_ir   <= i_cfg_data[scc_pkg::IR_W-1:0];
                scc_pkg::CFG_ATTACK:    r_att  <= i_cfg_data[CW-1:0];
                scc_pkg::CFG_RELEASE:   r_rel  <= i_cfg_data[CW-1:0];
                scc_pkg::CFG_MAKEUP:    r_mk   <= i_cfg_data[MW-1:0];
                scc_pkg::CFG_SIDE_EN:   r_side <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Key detection: sidechain peak, falling back to the larger of the sidechain and main peaks when off or silent.
    assign w_mag_sl   = mag_of(i_side_left);
    assign w_mag_sr   = mag_of(i_side_right);
    assign w_mag_ml   = mag_of(i_main_left);
    assign w_mag_mr   = mag_of(i_main_right);
    assign w_side_key = r_side ? max_of(w_mag_sl, w_mag_sr) : '0;
    assign w_main_key = max_of(w_mag_ml, w_mag_mr);
    assign w_fallback = !r_side || (w_side_key < KEY_FLOOR);
    assign w_key      = w_fallback ? max_of(w_side_key, w_main_key) : w_side_key;

    // Envelope distance to the key.
    assign w_diff = (r_key > r_env) ? (r_key - r_env) : (r_env - r_key);

    // Threshold aligned to the sample width; zero counts as one.
    if (SB >= 24) begin : g_thr_up
        assign w_thr_raw = (SB - 1)'(r_thr) << (SB - 24);
    end else begin : g_thr_dn
        assign w_thr_raw = r_thr[scc_pkg::THR_W-1:24-SB];
    end
    assign w_thr = (w_thr_raw == '0) ? SB'(1) : SB'(w_thr_raw);

    scc_log2 #(.SAMPLE_BITS(SB), .LG_DEPTH(LG_DEPTH)) u_log_env (
        .i_x   (r_env),
        .o_log (w_le)
    );

    scc_log2 #(.SAMPLE_BITS(SB), .LG_DEPTH(LG_DEPTH)) u_log_thr (
        .i_x   (w_thr),
        .o_log (w_lt)
    );

    // Slope: one minus the inverse ratio, with ratios below unity clamped.
    assign w_ir    = (r_ir > scc_pkg::GAIN_UNITY) ? scc_pkg::GAIN_UNITY : r_ir;
    assign w_cr    = scc_pkg::GAIN_UNITY - w_ir;
    assign w_eprod = (LOG_W + GW)'(r_l) * (LOG_W + GW)'(w_cr);

    // Exponent table, fixed at elaboration.
    for (genvar g = 0; g < DEPTH; g++) begin : g_etab
        assign w_etab[g] = scc_pkg::exp_entry(g, LG_DEPTH);
    end

    // Gain: split the attenuation into a whole shift and a table fraction.
    assign w_esum = (E_W + 1)'(r_e) + (E_W + 1)'(16'hFFFF);
    assign w_n    = w_esum[E_W:16];
    assign w_rem  = 16'd0 - r_e[15:0];
    assign w_exp  = w_etab[w_rem[15:16-LG_DEPTH]];
    assign w_gain = (w_n >= N_W'(18)) ? '0 : (w_exp >> w_n);

    // Frame steps.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ml  <= i_main_left;
            r_mr  <= i_main_right;
            r_key <= w_key;
        end
        if (i_cmd.env_mul) begin
            r_rise  <= r_key > r_env;
            r_dprod <= DPROD_W'(w_diff) * DPROD_W'((r_key > r_env) ? r_att : r_rel);
        end
        if (i_cmd.log_step) begin
            r_above <= r_env > w_thr;
            r_l     <= (w_le > w_lt) ? (w_le - w_lt) : '0;
        end
        if (i_cmd.exp_step) begin
            r_e <= w_eprod[LOG_W+GW-1:16];
        end
        if (i_cmd.gain) begin
            r_gain <= r_above ? w_gain : scc_pkg::GAIN_UNITY;
        end
        if (i_cmd.scale) begin
            r_p_l <= P_W'(mag_of(r_ml)) * P_W'(r_gain);
            r_p_r <= P_W'(mag_of(r_mr)) * P_W'(r_gain);
        end
        if (i_cmd.makeup) begin
            r_hi_l <= HI_W'(r_p_l[P_W-1:32]) * HI_W'(r_mk);
            r_hi_r <= HI_W'(r_p_r[P_W-1:32]) * HI_W'(r_mk);
            r_lo_l <= LO_W'(r_p_l[31:0]) * LO_W'(r_mk);
            r_lo_r <= LO_W'(r_p_r[31:0]) * LO_W'(r_mk);
        end
        if (i_cmd.finish) begin
            r_out_l <= finish_of(r_hi_l, r_lo_l, r_ml[SB-1]);
            r_out_r <= finish_of(r_hi_r, r_lo_r, r_mr[SB-1]);
            r_out_g <= r_gain;
        end
    end

    // Envelope state moves towards the key, never past it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env <= '0;
        end else if (i_cmd.env_upd) begin
            r_env <= r_rise ? (r_key - r_dprod[DPROD_W-1:CW])
                            : (r_key + r_dprod[DPROD_W-1:CW]);
        end
    end

    assign o_out_left     = r_out_l;
    assign o_out_right    = r_out_r;
    assign o_gain_applied = r_out_g;

    `SCC_ASSERT_RST(a_env_between, i_cmd.env_upd |=> ((r_rise && r_env <= r_key && r_env >= $past(r_env)) || (!r_rise && r_env >= r_key && r_env <= $past(r_env))), "envelope left the key and old envelope span")
    `SCC_ASSERT_RST(a_gain_bound, i_cmd.gain |=> r_gain <= scc_pkg::GAIN_UNITY, "gain above unity")
    `SCC_ASSERT_RST(a_gain_unity, (i_cmd.gain && !r_above) |=> r_gain == scc_pkg::GAIN_UNITY, "gain not unity below threshold")

endmodule

`default_nettype wire

/* rtl/sidechain_compressor_core.sv */
// Sidechain peak compressor, one stereo frame per transaction.
// A new frame is taken only once the previous one has been loaded into the output register,
// as the sequencer steps one shared datapath through envelope, log, exponent, scaling and
// makeup steps; a stalled output result holds the sequencer in its done step.
// Reset (synchronous, active low): registers to defaults, envelope to zero, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module sidechain_compressor_core #(
    parameter int SAMPLE_BITS     = scc_pkg::SAMPLE_BITS_DEF,
    parameter int LOG_TABLE_DEPTH = scc_pkg::LOG_TABLE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [scc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [scc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_main_left,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_main_right,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_side_left,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_side_right,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed      [SAMPLE_BITS-1:0]     o_out_left,
    output logic signed      [SAMPLE_BITS-1:0]     o_out_right,
    output logic [scc_pkg::GAIN_W-1:0]             o_gain_applied
);

    localparam int LG_DEPTH = $clog2(LOG_TABLE_DEPTH);

    scc_pkg::t_dp_cmd w_cmd;

    // Registers take a write in any cycle.
    assign o_cfg_ready = 1'b1;

    scc_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    scc_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LG_DEPTH    (LG_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_main_left    (i_main_left),
        .i_main_right   (i_main_right),
        .i_side_left    (i_side_left),
        .i_side_right   (i_side_right),
        .o_out_left     (o_out_left),
        .o_out_right    (o_out_right),
        .o_gain_applied (o_gain_applied)
    );

endmodule

`default_nettype wire

/* test/sidechain_compressor_core_check.sv */
`timescale 1ns / 1ps

module sidechain_compressor_core_check (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [scc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [scc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_stall,
    input  wire logic signed [23:0]              i_main_left,
    input  wire logic signed [23:0]              i_main_right,
    input  wire logic signed [23:0]              i_side_left,
    input  wire logic signed [23:0]              i_side_right,
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_stall,
    input  wire logic signed [23:0]              i_out_left,
    input  wire logic signed [23:0]              i_out_right,
    input  wire logic [scc_pkg::GAIN_W-1:0]      i_gain_applied,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import scc_pkg::*;

    typedef struct {
        logic [23:0] left;
        logic [23:0] right;
        logic [16:0] gain;
    } t_frame_out;

    t_frame_out frame_q[$];

    // Shadow registers and envelope of the compressor.
    logic [63:0] thr_reg, ir_reg, att_reg, rel_reg, mkp_reg, side_reg, env_level;
    logic [15:0] log_lut [256];
    logic [16:0] exp_lut [256];
    int          report_count;

    // Lookup tables built the same way as the hardware tables are specified.
    initial begin : build_luts
        logic [63:0] y;
        logic [63:0] f;
        logic [15:0] res;
        for (int i = 0; i < 256; i++) begin
            y   = (64'd1 << 30) + ((64'(i) << 30) / 256);
            res = '0;
            for (int k = 1; k <= 16; k++) begin
                y = (y * y) >> 30;
                if (y >= (64'd1 << 31)) begin
                    y = y >> 1;
                    res[16-k] = 1'b1;
                end
            end
            log_lut[i] = res;
            f = (64'(i) << 16) / 256;
            y = 64'd1 << 30;
            for (int k = 1; k <= 16; k++) begin
                if (f[16-k]) begin
                    y = (y * 64'(EXP_ROOT[k-1])) >> 30;
                end
            end
            exp_lut[i] = 17'(y >> 14);
        end
    end

    function automatic logic [63:0] magnitude(input logic signed [23:0] s);
        longint v;
        v = s;
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Q.16 log2 with the integer part from the leading one.
    function automatic logic [63:0] log2_fix(input logic [63:0] x);
        logic [63:0] p;
        logic [63:0] idx;
        p = 0;
        while (p < 63 && (x >> (p + 1)) != 0) p++;
        idx = ((x - (64'd1 << p)) * 256) >> p;
        if (idx > 255) idx = 255;
        return p * 65536 + 64'(log_lut[idx]);
    endfunction

    // Rounded scaling by gain and makeup, saturated to the sample range.
    function automatic logic [23:0] scale_sample(input logic signed [23:0] s,
                                                 input logic [63:0] gain);
        logic [63:0] prod;
        logic [63:0] r;
        prod = magnitude(s) * gain;
        r = (prod >> 32) * mkp_reg + (((prod & 64'hFFFF_FFFF) * mkp_reg + 64'h8000_0000) >> 32);
        if (s < 0) begin
            if (r > 64'h80_0000) r = 64'h80_0000;
            return 24'(-r);
        end
        if (r > 64'h7F_FFFF) r = 64'h7F_FFFF;
        return 24'(r);
    endfunction

    // Works out one output frame and advances the envelope.
    task automatic predict_frame(input logic signed [23:0] ml, mr, sl, sr,
                                 output t_frame_out res);
        logic [63:0] key, thr, gain, ir, lg, e, n, r, idx;
        key  = 0;
        gain = 65536;
        if (side_reg != 0) begin
            key = (magnitude(sl) > magnitude(sr)) ? magnitude(sl) : magnitude(sr);
        end
        if (side_reg == 0 || key * 1000000 < (64'd1 << 23)) begin
            if (magnitude(ml) > key) key = magnitude(ml);
            if (magnitude(mr) > key) key = magnitude(mr);
        end
        if (key > env_level) env_level = key - (((key - env_level) * att_reg) >> 24);
        else env_level = key + (((env_level - key) * rel_reg) >> 24);
        thr = (thr_reg == 0) ? 1 : thr_reg;
        if (env_level > thr) begin
            ir  = (ir_reg > 65536) ? 65536 : ir_reg;
            lg  = (log2_fix(env_level) > log2_fix(thr)) ? log2_fix(env_level) - log2_fix(thr) : 0;
            e   = (lg * (65536 - ir)) >> 16;
            n   = (e + 65535) >> 16;
            r   = n * 65536 - e;
            idx = (r * 256) >> 16;
            if (idx > 255) idx = 255;
            gain = (n >= 18) ? 0 : (64'(exp_lut[idx]) >> n);
        end
        res.left  = scale_sample(ml, gain);
        res.right = scale_sample(mr, gain);
        res.gain  = 17'(gain);
    endtask

    assign o_pending = frame_q.size();

    // Watch the three channels at each rising edge.
    always @(posedge i_clk) begin : watch
        t_frame_out exp_frame;
        t_frame_out got;
        if (!i_rst_n) begin
            frame_q.delete();
            thr_reg   <= 64'(THR_RST);
            ir_reg    <= 64'(IR_RST);
            att_reg   <= 64'(ATTACK_RST);
            rel_reg   <= 64'(RELEASE_RST);
            mkp_reg   <= 64'(MAKEUP_RST);
            side_reg  <= 64'(SIDE_EN_RST);
            env_level <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: thr_reg  <= 64'(i_cfg_data[THR_W-1:0]);
                    CFG_INV_RATIO: ir_reg   <= 64'(i_cfg_data[IR_W-1:0]);
                    CFG_ATTACK:    att_reg  <= 64'(i_cfg_data);
                    CFG_RELEASE:   rel_reg  <= 64'(i_cfg_data);
                    CFG_MAKEUP:    mkp_reg  <= 64'(i_cfg_data[MAKEUP_W-1:0]);
                    CFG_SIDE_EN:   side_reg <= 64'(i_cfg_data[0]);
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_frame(i_main_left, i_main_right, i_side_left, i_side_right, exp_frame);
                frame_q.push_back(exp_frame);
            end
            if (i_out_valid && !i_out_stall) begin
                got.left  = i_out_left;
                got.right = i_out_right;
                got.gain  = i_gain_applied;
                if (frame_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (report_count < 10) begin
                        $display("Unexpected output frame: left %0d right %0d gain %0d",
                                 $signed(got.left), $signed(got.right), got.gain);
                    end
                    report_count++;
                end else begin
                    exp_frame = frame_q.pop_front();
                    if (got.left != exp_frame.left || got.right != exp_frame.right ||
                        got.gain != exp_frame.gain) begin
                        o_fail_count <= o_fail_count + 1;
                        if (report_count < 10) begin
                            $display("Mismatch: expected left %0d right %0d gain %0d, got left %0d right %0d gain %0d",
                                     $signed(exp_frame.left), $signed(exp_frame.right),
                                     exp_frame.gain, $signed(got.left), $signed(got.right),
                                     got.gain);
                        end
                        report_count++;
                    end
                end
            end
        end
    end

    initial begin
        o_fail_count = 0;
        report_count = 0;
    end

endmodule

/* test/sidechain_compressor_core_test.sv */
`timescale 1ns / 1ps

module sidechain_compressor_core_test;
    import scc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk, i_rst_n;
    logic                  i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid, o_in_stall;
    logic signed [23:0]    i_main_left, i_main_right, i_side_left, i_side_right;
    logic                  o_out_valid, i_out_stall;
    logic signed [23:0]    o_out_left, o_out_right;
    logic [GAIN_W-1:0]     o_gain_applied;
    int                    fail_count, pending;
    int                    cycle_count;
    int                    hold_cycles;
    bit                    quiet;

    sidechain_compressor_core u_top (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .o_in_stall, .i_main_left, .i_main_right, .i_side_left,
        .i_side_right, .o_out_valid, .i_out_stall, .o_out_left, .o_out_right,
        .o_gain_applied
    );

    sidechain_compressor_core_check u_check (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_in_valid, .i_in_stall(o_in_stall), .i_main_left,
        .i_main_right, .i_side_left, .i_side_right, .i_out_valid(o_out_valid),
        .i_out_stall, .i_out_left(o_out_left), .i_out_right(o_out_right),
        .i_gain_applied(o_gain_applied), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sidechain_compressor_core test failed");
            $finish;
        end
    end

    // Output side: random stall bursts, an occasional long hold-off, none when quiet.
    initial begin : out_stall_gen
        int burst;
        int run;
        burst = 0;
        run   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else if (quiet) begin
                i_out_stall <= 1'b0;
            end else if (burst > 0) begin
                i_out_stall <= 1'b1;
                burst--;
            end else if (run > 0) begin
                i_out_stall <= 1'b0;
                run--;
            end else if ($urandom_range(0, 2) == 0) begin
                burst = $urandom_range(1, 13) - 1;
                i_out_stall <= 1'b1;
            end else begin
                run = $urandom_range(0, 30);
                i_out_stall <= 1'b0;
            end
        end
    end

    // One register write transaction.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain all frames in flight before touching the registers.
    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic set_all(input logic [CFG_DATA_W-1:0] thr, ir, att, rel, mkp, side);
        wait_idle();
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_INV_RATIO, ir);
        write_reg(CFG_ATTACK, att);
        write_reg(CFG_RELEASE, rel);
        write_reg(CFG_MAKEUP, mkp);
        write_reg(CFG_SIDE_EN, side);
    endtask

    // One frame transaction, with an optional idle gap ahead of it.
    task automatic send_frame(input logic signed [23:0] ml, mr, sl, sr);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_main_left  <= ml;
        i_main_right <= mr;
        i_side_left  <= sl;
        i_side_right <= sr;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    function automatic logic signed [23:0] rand_sample();
        logic [23:0] v;
        v = $urandom();
        case ($urandom_range(0, 5))
            0: return v;
            1: return $urandom_range(0, 8) * ($urandom_range(0, 1) ? 1 : -1);
            default: return $signed(v) >>> $urandom_range(0, 20);
        endcase
    endfunction

    // Mostly music-like frames, with silent sidechain and full-scale noise mixed in.
    task automatic send_random(input int count);
        logic signed [23:0] ml, mr, sl, sr;
        for (int n = 0; n < count; n++) begin
            ml = rand_sample();
            mr = rand_sample();
            sl = rand_sample();
            sr = rand_sample();
            if ($urandom_range(0, 7) == 0) begin
                sl = $urandom_range(0, 8);
                sr = -$signed(24'($urandom_range(0, 8)));
            end
            send_frame(ml, mr, sl, sr);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    localparam logic signed [23:0] SMAX = 24'sh7F_FFFF;
    localparam logic signed [23:0] SMIN = 24'sh80_0000;

    initial begin
        i_rst_n = 1'b0;  i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_main_left = '0; i_main_right = '0;
        i_side_left = '0; i_side_right = '0; i_out_stall = 1'b0;
        cycle_count = 0; hold_cycles = 0; quiet = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at reset settings: extremes, silent sidechain, attack and release.
        send_frame(0, 0, 0, 0);
        send_frame(SMAX, SMAX, SMAX, SMAX);
        send_frame(SMIN, SMIN, SMIN, SMIN);
        send_frame(SMAX, SMIN, 0, 0);
        send_frame(1000, -1000, 8, -8);
        send_frame(100, -100, 9, 0);
        send_frame(SMIN, SMAX, SMIN, SMAX);
        send_frame(10, 10, SMIN, 0);
        send_frame(SMAX, 5, 0, -7);
        send_frame(-1, 1, 3000000, -3000000);
        send_frame(0, 0, 0, 0);
        send_frame(12345, -54321, 0, 1);
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Lowest threshold, highest ratio, instant envelope, top makeup.
        set_all(8389, 3277, 0, 0, 1038676, 1);
        send_frame(SMAX, SMIN, 0, 0);
        send_frame(SMIN, SMIN, SMAX, SMAX);
        send_frame(1, -1, 0, 0);
        send_random(150);

        // Highest threshold, unity ratio, slowest envelope, main only.
        set_all(8388607, 65536, 16777215, 16777215, 65536, 0);
        send_frame(SMAX, SMIN, SMAX, SMIN);
        send_frame(0, 0, SMAX, SMAX);
        send_random(150);

        // Zero threshold, inverse ratio above unity, muted makeup, unknown indexes ignored.
        set_all(0, 131071, 8000000, 1000, 0, 1);
        write_reg(3'd6, 24'hFFFFFF);
        write_reg(3'd7, 24'h000000);
        send_frame(SMAX, SMIN, SMAX, SMIN);
        send_random(150);

        // Random mid-range settings, with a long output hold-off at the start.
        set_all($urandom_range(8389, 2000000), $urandom_range(3277, 65536),
                $urandom_range(0, 16777215), $urandom_range(0, 16777215),
                $urandom_range(65536, 1038676), $urandom_range(0, 1));
        hold_cycles = 300;
        send_random(250);

        // Final stretch with no idling on either side.
        set_all($urandom_range(8389, 8388607), $urandom_range(3277, 65536),
                $urandom_range(16000000, 16777215), $urandom_range(16000000, 16777215),
                $urandom_range(65536, 300000), 1);
        quiet = 1'b1;
        send_random(250);

        while (pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("sidechain_compressor_core test passed");
        end else begin
            $display("sidechain_compressor_core test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/scc_pkg.sv
rtl/scc_log2.sv
rtl/scc_controller.sv
rtl/scc_datapath.sv
rtl/sidechain_compressor_core.sv
test/sidechain_compressor_core_check.sv
test/sidechain_compressor_core_test.sv
